>>> hdl/lrh_pkg.sv
// ----------------------------------------------------------------------------
// lrh_pkg: shared types and constants for the largest rectangle block
// Holds the transaction payload structs, the register map and the fixed
// field widths of the histogram rectangle search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrh_pkg;

	// Fixed field widths
	localparam int VALUE_W = 16;
	localparam int AREA_W  = 26;
	localparam int ROW_W_W = 11;
	localparam int CFG_W   = 11;
	localparam int CFG_IDX_W = 1;

	// Parameter defaults
	localparam int MAX_COLS_DEF    = 1024;
	localparam int HEIGHT_BITS_DEF = 16;

	// Register map
	localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 1'b1;

	// Register reset values
	localparam logic               MODE_RST      = 1'b0;
	localparam logic [ROW_W_W-1:0] ROW_WIDTH_RST = 11'd1024;

	// Mode codes
	localparam logic MODE_HIST   = 1'b0;
	localparam logic MODE_MATRIX = 1'b1;

	localparam logic [AREA_W-1:0] AREA_MAX = '1;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} in_t;

	typedef struct packed {
		logic [AREA_W-1:0] max_area;
		logic              overflow;
	} out_t;

endpackage

>>> hdl/largest_rectangle_histogram.sv
// ----------------------------------------------------------------------------
// largest_rectangle_histogram: largest rectangle under a histogram or of ones
// Each bar is accepted, then pops and scores every stacked entry at least as tall, and is
// pushed; a matrix cell first reads and writes back its column height and sweeps skipped
// columns to zero; a row end or last transaction pops and scores every stacked entry, and
// the result rises once the score pipeline has drained and the result slot is free.
// Throughput: one item at a time, the input stalling while one is under work; each pushed
// entry is popped once. Reset: control state clears at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module largest_rectangle_histogram #(
	parameter int MAX_COLS    = lrh_pkg::MAX_COLS_DEF,
	parameter int HEIGHT_BITS = lrh_pkg::HEIGHT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  lrh_pkg::in_t                    in_item,
	// Result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output lrh_pkg::out_t                   out_item,
	// Configuration write port
	input  logic                            cfg_we,
	input  logic [lrh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lrh_pkg::CFG_W-1:0]       cfg_data
);

	// Address of one column or stack slot
	localparam int ADDR_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	// Stack depth and fill count, 0 to MAX_COLS
	localparam int DEPTH_W = $clog2(MAX_COLS + 1);
	// Column position: must hold MAX_COLS and any position inside a row
	localparam int COL_W   = (DEPTH_W > lrh_pkg::ROW_W_W) ? DEPTH_W : lrh_pkg::ROW_W_W;
	// Bar height before saturation
	localparam int VX_W    = (lrh_pkg::VALUE_W > HEIGHT_BITS) ? lrh_pkg::VALUE_W : HEIGHT_BITS;
	// Score product and its saturation compare
	localparam int PROD_W  = HEIGHT_BITS + COL_W;
	localparam int SAT_W   = (PROD_W > lrh_pkg::AREA_W) ? PROD_W : lrh_pkg::AREA_W + 1;

	localparam logic [COL_W-1:0]       MAX_C = COL_W'(MAX_COLS);
	localparam logic [DEPTH_W-1:0]     MAX_D = DEPTH_W'(MAX_COLS);
	localparam logic [HEIGHT_BITS-1:0] HMAX  = '1;

	typedef struct packed {
		logic [ADDR_W-1:0]      start;
		logic [HEIGHT_BITS-1:0] height;
	} stk_t;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_HGT   = 8'b0000_0010,
		S_SWEEP = 8'b0000_0100,
		S_POP   = 8'b0000_1000,
		S_LOAD  = 8'b0001_0000,
		S_FLUSH = 8'b0010_0000,
		S_FLOAD = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	// Control
	state_t                     state_q, state_d;
	logic                       mode_q;
	logic [lrh_pkg::ROW_W_W-1:0] row_width_q;
	logic [COL_W-1:0]           col_idx_q, col_idx_d;
	logic [DEPTH_W-1:0]         depth_q, depth_d;
	logic [DEPTH_W-1:0]         fill_q, fill_d;
	logic [lrh_pkg::AREA_W-1:0] best_q, best_d;
	logic                       ovf_q, ovf_d;
	logic                       out_valid_q, out_valid_d;
	logic                       sc_v_s1, sc_v_s1_d;
	logic                       sc_v_s2;

	// Datapath of the item under work
	logic [COL_W-1:0]           col_q, col_d;
	logic [HEIGHT_BITS-1:0]     h_q, h_d;
	logic [ADDR_W-1:0]          start_q, start_d;
	logic [COL_W-1:0]           fcols_q, fcols_d;
	logic                       flush_q, flush_d;
	logic                       last_q, last_d;
	logic                       vnz_q, vnz_d;
	stk_t                       top_q, top_d;
	lrh_pkg::out_t              out_q, out_d;

	// Score pipeline: operands, then product
	logic [HEIGHT_BITS-1:0]     sc_h_s1, sc_h_s1_d;
	logic [COL_W-1:0]           sc_w_s1, sc_w_s1_d;
	logic [PROD_W-1:0]          sc_p_s2;

	// Memories
	logic [HEIGHT_BITS-1:0]     ch_mem [MAX_COLS];
	logic [HEIGHT_BITS-1:0]     ch_rdata_q;
	logic                       ch_we, ch_re;
	logic [ADDR_W-1:0]          ch_waddr, ch_raddr;
	logic [HEIGHT_BITS-1:0]     ch_wdata;

	stk_t                       st_mem [MAX_COLS];
	stk_t                       st_rdata_q;
	logic                       st_we, st_re;
	logic [ADDR_W-1:0]          st_waddr, st_raddr;

	// ------------------------------------------------------------------
	// Combinational helpers
	// ------------------------------------------------------------------
	logic                       in_acc;
	logic                       out_take;
	logic [VX_W-1:0]            v_ext;
	logic [HEIGHT_BITS-1:0]     h_in;
	logic [lrh_pkg::ROW_W_W-1:0] rw;
	logic [COL_W:0]             colp1;
	logic                       row_end;
	logic [HEIGHT_BITS-1:0]     h_old;
	logic [SAT_W-1:0]           prod_ext;
	logic [lrh_pkg::AREA_W-1:0] area;
	logic                       pop_hit;

	assign in_acc   = in_valid && (state_q == S_IDLE);
	assign out_take = out_valid_q && !out_stall;

	// Saturate the incoming bar height to the height range
	assign v_ext = VX_W'(in_item.value);
	assign h_in  = (v_ext > VX_W'(HMAX)) ? HMAX : v_ext[HEIGHT_BITS-1:0];

	// Row end test for matrix mode; a zero row width counts as one
	assign rw      = (row_width_q == '0) ? lrh_pkg::ROW_W_W'(1) : row_width_q;
	assign colp1   = (COL_W+1)'(col_idx_q) + (COL_W+1)'(1);
	assign row_end = (colp1 >= (COL_W+1)'(rw)) || in_item.last;

	// Column heights beyond the fill count read as zero
	assign h_old = ((COL_W'(fill_q) <= col_q) ? '0 : ch_rdata_q);

	// Saturate the score to the area range
	assign prod_ext = SAT_W'(sc_p_s2);
	assign area     = (prod_ext > SAT_W'(lrh_pkg::AREA_MAX)) ? lrh_pkg::AREA_MAX
	                                                          : prod_ext[lrh_pkg::AREA_W-1:0];

	assign pop_hit = (depth_q != '0) && (top_q.height >= h_q);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_d     = state_q;
		col_idx_d   = col_idx_q;
		depth_d     = depth_q;
		fill_d      = fill_q;
		best_d      = best_q;
		ovf_d       = ovf_q;
		out_valid_d = out_valid_q;
		col_d       = col_q;
		h_d         = h_q;
		start_d     = start_q;
		fcols_d     = fcols_q;
		flush_d     = flush_q;
		last_d      = last_q;
		vnz_d       = vnz_q;
		top_d       = top_q;
		out_d       = out_q;
		sc_v_s1_d   = 1'b0;
		sc_h_s1_d   = sc_h_s1;
		sc_w_s1_d   = sc_w_s1;
		ch_we       = 1'b0;
		ch_re       = 1'b0;
		ch_waddr    = col_q[ADDR_W-1:0];
		ch_raddr    = col_idx_q[ADDR_W-1:0];
		ch_wdata    = h_q;
		st_we       = 1'b0;
		st_re       = 1'b0;
		st_waddr    = ADDR_W'(depth_q - DEPTH_W'(1));
		st_raddr    = ADDR_W'(depth_q - DEPTH_W'(2));

		// Drop the result once taken
		if (out_take) begin
			out_valid_d = 1'b0;
		end

		// Keep the best saturated score
		if (sc_v_s2 && (area > best_q)) begin
			best_d = area;
		end

		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					col_d   = col_idx_q;
					h_d     = h_in;
					start_d = col_idx_q[ADDR_W-1:0];
					last_d  = in_item.last;
					vnz_d   = (in_item.value != '0);
					if (mode_q == lrh_pkg::MODE_HIST) begin
						flush_d = in_item.last;
						if (col_idx_q >= MAX_C) begin
							// Histogram too long: drop the bar
							ovf_d   = 1'b1;
							fcols_d = col_idx_q;
							state_d = in_item.last ? S_FLUSH : S_IDLE;
						end else begin
							col_idx_d = col_idx_q + COL_W'(1);
							fcols_d   = col_idx_q + COL_W'(1);
							state_d   = S_POP;
						end
					end else begin
						flush_d   = row_end;
						fcols_d   = (colp1 > (COL_W+1)'(MAX_COLS)) ? MAX_C : colp1[COL_W-1:0];
						col_idx_d = row_end ? '0 : colp1[COL_W-1:0];
						if (col_idx_q < MAX_C) begin
							// Fetch the column height
							ch_re   = 1'b1;
							state_d = S_HGT;
						end else begin
							// Cell beyond the column limit: drop it
							ovf_d   = 1'b1;
							state_d = row_end ? S_FLUSH : S_IDLE;
						end
					end
				end
			end

			S_HGT: begin
				if (vnz_q) begin
					h_d = (h_old == HMAX) ? HMAX : h_old + HEIGHT_BITS'(1);
				end else begin
					h_d = '0;
				end
				state_d = S_SWEEP;
			end

			S_SWEEP: begin
				if (COL_W'(fill_q) < col_q) begin
					// Zero a column skipped since the last set began
					ch_we    = 1'b1;
					ch_waddr = fill_q[ADDR_W-1:0];
					ch_wdata = '0;
					fill_d   = fill_q + DEPTH_W'(1);
				end else begin
					ch_we    = 1'b1;
					ch_waddr = col_q[ADDR_W-1:0];
					ch_wdata = h_q;
					if (col_q >= COL_W'(fill_q)) begin
						fill_d = DEPTH_W'(col_q + COL_W'(1));
					end
					state_d = S_POP;
				end
			end

			S_POP: begin
				if (pop_hit) begin
					// Score the popped entry and take over its start
					sc_v_s1_d = 1'b1;
					sc_h_s1_d = top_q.height;
					sc_w_s1_d = col_q - COL_W'(top_q.start);
					start_d   = top_q.start;
					depth_d   = depth_q - DEPTH_W'(1);
					if (depth_q > DEPTH_W'(1)) begin
						st_re   = 1'b1;
						state_d = S_LOAD;
					end
				end else begin
					if (depth_q < MAX_D) begin
						// Spill the old top and push the new bar
						if (depth_q != '0) begin
							st_we = 1'b1;
						end
						top_d.start  = start_q;
						top_d.height = h_q;
						depth_d      = depth_q + DEPTH_W'(1);
					end
					state_d = flush_q ? S_FLUSH : S_IDLE;
				end
			end

			S_LOAD: begin
				top_d   = st_rdata_q;
				state_d = S_POP;
			end

			S_FLUSH: begin
				if (depth_q != '0) begin
					sc_v_s1_d = 1'b1;
					sc_h_s1_d = top_q.height;
					sc_w_s1_d = fcols_q - COL_W'(top_q.start);
					depth_d   = depth_q - DEPTH_W'(1);
					if (depth_q > DEPTH_W'(1)) begin
						st_re   = 1'b1;
						state_d = S_FLOAD;
					end
				end else begin
					state_d = last_q ? S_DONE : S_IDLE;
				end
			end

			S_FLOAD: begin
				top_d   = st_rdata_q;
				state_d = S_FLUSH;
			end

			S_DONE: begin
				// Wait for the score pipeline to drain and the result slot to free
				if (!sc_v_s1 && !sc_v_s2 && (!out_valid_q || !out_stall)) begin
					out_d.max_area = best_q;
					out_d.overflow = ovf_q;
					out_valid_d    = 1'b1;
					best_d         = '0;
					ovf_d          = 1'b0;
					col_idx_d      = '0;
					depth_d        = '0;
					fill_d         = '0;
					state_d        = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= lrh_pkg::MODE_RST;
			row_width_q <= lrh_pkg::ROW_WIDTH_RST;
			col_idx_q   <= '0;
			depth_q     <= '0;
			fill_q      <= '0;
			best_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			sc_v_s1     <= 1'b0;
			sc_v_s2     <= 1'b0;
		end else begin
			state_q     <= state_d;
			col_idx_q   <= col_idx_d;
			depth_q     <= depth_d;
			fill_q      <= fill_d;
			best_q      <= best_d;
			ovf_q       <= ovf_d;
			out_valid_q <= out_valid_d;
			sc_v_s1     <= sc_v_s1_d;
			sc_v_s2     <= sc_v_s1;
			if (cfg_we) begin
				unique case (cfg_index)
					lrh_pkg::CFG_MODE:      mode_q      <= cfg_data[0];
					lrh_pkg::CFG_ROW_WIDTH: row_width_q <= cfg_data[lrh_pkg::ROW_W_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers and the shared score multiplier
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		col_q   <= col_d;
		h_q     <= h_d;
		start_q <= start_d;
		fcols_q <= fcols_d;
		flush_q <= flush_d;
		last_q  <= last_d;
		vnz_q   <= vnz_d;
		top_q   <= top_d;
		out_q   <= out_d;
		sc_h_s1 <= sc_h_s1_d;
		sc_w_s1 <= sc_w_s1_d;
		sc_p_s2 <= PROD_W'(sc_h_s1) * PROD_W'(sc_w_s1);
	end

	// Column heights: one write, one registered read
	always_ff @(posedge clk) begin
		if (ch_we) begin
			ch_mem[ch_waddr] <= ch_wdata;
		end
		if (ch_re) begin
			ch_rdata_q <= ch_mem[ch_raddr];
		end
	end

	// Stack below the top entry: one write, one registered read
	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_waddr] <= top_q;
		end
		if (st_re) begin
			st_rdata_q <= st_mem[st_raddr];
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
`ifndef SYNTHESIS
	// A result is only raised from the completion state
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE))
		else $error("result raised outside completion");

	// A stack refill only follows a pop that left entries behind
	a_load_needs_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD || state_q == S_FLOAD) |-> (depth_q != '0))
		else $error("stack refill with empty stack");

	// The sweep advances the fill count by one column a cycle
	a_sweep_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP && COL_W'(fill_q) < col_q) |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("sweep did not advance");

	// The result is never loaded while scores are still in flight
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && state_d == S_IDLE) |-> (!sc_v_s1 && !sc_v_s2))
		else $error("result taken before score pipeline drained");
`endif

endmodule

>>> tb/sv/largest_rectangle_histogram_checker.sv
// ----------------------------------------------------------------------------
// largest_rectangle_histogram_checker: scoreboard for the rectangle search
// Watches the register port and both transaction channels, tracks the bar
// stack and column heights of each data set, and compares every result with
// the area and overflow flag expected for it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module largest_rectangle_histogram_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  lrh_pkg::in_t                  in_item,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  lrh_pkg::out_t                 out_item,
	input  logic                          cfg_we,
	input  logic [lrh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lrh_pkg::CFG_W-1:0]     cfg_data,
	output int                            fail_count,
	output int                            pending
);

	localparam int          COLS       = lrh_pkg::MAX_COLS_DEF;
	localparam int          HEIGHT_TOP = (1 << lrh_pkg::HEIGHT_BITS_DEF) - 1;
	localparam logic [63:0] AREA_TOP   = (64'd1 << lrh_pkg::AREA_W) - 64'd1;

	logic                                mode_r;
	logic [lrh_pkg::ROW_W_W-1:0]         row_width_r;
	logic [lrh_pkg::VALUE_W-1:0]         col_height [COLS];
	logic [10:0]                         run_start  [COLS];
	logic [lrh_pkg::VALUE_W-1:0]         run_height [COLS];
	logic [10:0]                         run_depth;
	logic [10:0]                         col_pos;
	logic [lrh_pkg::AREA_W-1:0]          best_area;
	logic                                overflow_seen;
	lrh_pkg::out_t                       expected_areas [$];
	lrh_pkg::out_t                       want;
	int                                  fails = 0;

	assign fail_count = fails;

	function automatic void score_run(input logic [lrh_pkg::VALUE_W-1:0] h, input int from,
			input int upto);
		logic [63:0] area;
		area = 64'(h) * 64'(upto - from);
		if (area > AREA_TOP)
			area = AREA_TOP;
		if (area > 64'(best_area))
			best_area = area[lrh_pkg::AREA_W-1:0];
	endfunction

	// Pop every run at least as tall as the new bar, then push it
	function automatic void push_run(input int col, input logic [lrh_pkg::VALUE_W-1:0] h);
		int start;
		start = col;
		while (run_depth > 0 && run_height[run_depth - 1] >= h) begin
			run_depth = run_depth - 11'd1;
			score_run(run_height[run_depth], run_start[run_depth], col);
			start = run_start[run_depth];
		end
		if (run_depth < COLS) begin
			run_start[run_depth]  = start[10:0];
			run_height[run_depth] = h;
			run_depth = run_depth + 11'd1;
		end
	endfunction

	function automatic void flush_runs(input int cols);
		while (run_depth > 0) begin
			run_depth = run_depth - 11'd1;
			score_run(run_height[run_depth], run_start[run_depth], cols);
		end
	endfunction

	function automatic void clear_set();
		for (int i = 0; i < COLS; i++)
			col_height[i] = '0;
		run_depth     = '0;
		col_pos       = '0;
		best_area     = '0;
		overflow_seen = 1'b0;
	endfunction

	function automatic void absorb_item(input lrh_pkg::in_t it);
		int                          rw;
		int                          col;
		int                          used;
		logic [lrh_pkg::VALUE_W-1:0] h;
		lrh_pkg::out_t               res;
		if (mode_r == lrh_pkg::MODE_HIST) begin
			// bar heights already fit the height width, so no clamp is needed
			if (col_pos >= COLS) begin
				overflow_seen = 1'b1;
			end else begin
				push_run(col_pos, it.value);
				col_pos = col_pos + 11'd1;
			end
			if (it.last)
				flush_runs(col_pos);
		end else begin
			rw  = (row_width_r == 0) ? 1 : int'(row_width_r);
			col = col_pos;
			if (col < COLS) begin
				h = col_height[col];
				if (it.value != 0) begin
					if (h < HEIGHT_TOP)
						h = h + 1'b1;
				end else begin
					h = '0;
				end
				col_height[col] = h;
				push_run(col, h);
			end else begin
				overflow_seen = 1'b1;
			end
			col++;
			used = (col > COLS) ? COLS : col;
			if (col >= rw || it.last) begin
				flush_runs(used);
				col_pos = '0;
			end else begin
				col_pos = col[10:0];
			end
		end
		if (it.last) begin
			res.max_area = best_area;
			res.overflow = overflow_seen;
			expected_areas = {expected_areas, res};
			clear_set();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_r      = lrh_pkg::MODE_RST;
			row_width_r = lrh_pkg::ROW_WIDTH_RST;
			clear_set();
			expected_areas.delete();
			pending <= 0;
		end else begin
			// results first, so a new set never pairs with an unexpected result
			if (out_valid && !out_stall) begin
				if (expected_areas.size() == 0) begin
					$error("unexpected result: max_area %0d, overflow %0d",
						out_item.max_area, out_item.overflow);
					fails++;
				end else begin
					want = expected_areas.pop_front();
					if (out_item.max_area !== want.max_area) begin
						$error("max_area: expected %0d, actual %0d",
							want.max_area, out_item.max_area);
						fails++;
					end
					if (out_item.overflow !== want.overflow) begin
						$error("overflow: expected %0d, actual %0d",
							want.overflow, out_item.overflow);
						fails++;
					end
				end
			end
			if (in_valid && !in_stall)
				absorb_item(in_item);
			if (cfg_we) begin
				if (cfg_index == lrh_pkg::CFG_MODE)
					mode_r = cfg_data[0];
				else if (cfg_index == lrh_pkg::CFG_ROW_WIDTH)
					row_width_r = cfg_data[lrh_pkg::ROW_W_W-1:0];
			end
			pending <= expected_areas.size();
		end
	end

endmodule

>>> tb/sv/largest_rectangle_histogram_tb.sv
// ----------------------------------------------------------------------------
// largest_rectangle_histogram_tb: top level of the rectangle search bench
// Drives directed and random data sets in both modes through the block under
// several register settings and idling patterns, and gives the verdict from
// the failure count of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module largest_rectangle_histogram_tb;

	// Worst single item: a full stack of pops, a column sweep and the
	// multiplier pipeline, rounded up well clear
	localparam int DRAIN_CYCLES = 4096;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	lrh_pkg::in_t                  in_item   = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	lrh_pkg::out_t                 out_item;
	logic                          cfg_we    = 1'b0;
	logic [lrh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [lrh_pkg::CFG_W-1:0]     cfg_data  = '0;

	int   fail_count;
	int   pending;
	int   send_idle_pct = 0;
	int   stall_pct     = 0;
	logic cur_mode      = lrh_pkg::MODE_RST;

	always #5 clk = ~clk;

	// Stall the result channel at random, cycle by cycle
	always @(posedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	largest_rectangle_histogram u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	largest_rectangle_histogram_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Offer one transaction, idling first at random; hold the payload until
	// the edge at which the block takes it
	task automatic send_item(input logic [lrh_pkg::VALUE_W-1:0] v, input logic lst);
		lrh_pkg::in_t item;
		item.value = v;
		item.last  = lst;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= item;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Drop valid, wait for every expected result, then let the block settle;
	// the first edge lets the checker count a transaction taken just now
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// Write the mode register and then the row width register while the block is idle
	task automatic set_regs(input logic m, input logic [lrh_pkg::ROW_W_W-1:0] rw);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= lrh_pkg::CFG_MODE;
		cfg_data  <= lrh_pkg::CFG_W'(m);
		@(posedge clk);
		cfg_index <= lrh_pkg::CFG_ROW_WIDTH;
		cfg_data  <= rw;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_mode   = m;
	endtask

	// Bar heights: mostly small, so runs both grow and get popped, with the
	// extremes and the full range mixed in
	function automatic logic [lrh_pkg::VALUE_W-1:0] pick_bar();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			2, 3: begin
				return lrh_pkg::VALUE_W'($urandom_range(0, 65535));
			end
			default: begin
				return lrh_pkg::VALUE_W'($urandom_range(0, 15));
			end
		endcase
	endfunction

	// Matrix cells: mostly ones, some zeros, and now and then a wide nonzero value
	function automatic logic [lrh_pkg::VALUE_W-1:0] pick_cell();
		case ($urandom_range(0, 7))
			0, 1: begin
				return '0;
			end
			2: begin
				return lrh_pkg::VALUE_W'($urandom_range(1, 65535));
			end
			default: begin
				return lrh_pkg::VALUE_W'(1);
			end
		endcase
	endfunction

	// Send whole data sets of random length until the item budget is spent;
	// most are short, so results come often
	task automatic send_sets(input int budget);
		int sent;
		int len;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(13, 60);
			else
				len = $urandom_range(1, 12);
			for (int k = 0; k < len; k++)
				send_item(cur_mode ? pick_cell() : pick_bar(), k == len - 1);
			sent += len;
		end
	endtask

	// One long data set of a fixed kind
	task automatic send_long(input int len, input bit all_ones);
		for (int k = 0; k < len; k++) begin
			if (all_ones)
				send_item(lrh_pkg::VALUE_W'($urandom_range(1, 65535)), k == len - 1);
			else
				send_item(cur_mode ? pick_cell() : pick_bar(), k == len - 1);
		end
	endtask

	// A phase walks histogram mode, narrow rows, one extreme row width and
	// random row widths
	task automatic run_phase(input int budget, input logic [lrh_pkg::ROW_W_W-1:0] wide_rw);
		set_regs(lrh_pkg::MODE_HIST, lrh_pkg::ROW_W_W'($urandom_range(1, 2047)));
		send_sets(budget / 4);
		set_regs(lrh_pkg::MODE_MATRIX, lrh_pkg::ROW_W_W'($urandom_range(2, 8)));
		send_sets(budget / 4);
		set_regs(lrh_pkg::MODE_MATRIX, wide_rw);
		send_sets(budget / 4);
		set_regs(lrh_pkg::MODE_MATRIX, lrh_pkg::ROW_W_W'($urandom_range(1, 40)));
		send_sets(budget / 4);
	endtask

	initial begin
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		// Directed: registers still at reset, histogram mode
		// a lone last transaction with no area
		send_item(16'd0, 1'b1);
		// tallest bars side by side
		send_item(16'hFFFF, 1'b0);
		send_item(16'hFFFF, 1'b1);
		// the classic rise and fall shape
		send_item(16'd2, 1'b0);
		send_item(16'd1, 1'b0);
		send_item(16'd5, 1'b0);
		send_item(16'd6, 1'b0);
		send_item(16'd2, 1'b0);
		send_item(16'd3, 1'b1);

		// Matrix of three columns, ending on a partial row
		set_regs(lrh_pkg::MODE_MATRIX, 11'd3);
		send_item(16'd1, 1'b0);
		send_item(16'd0, 1'b0);
		send_item(16'd1, 1'b0);
		send_item(16'd1, 1'b0);
		send_item(16'd1, 1'b0);
		send_item(16'd1, 1'b0);
		send_item(16'h8000, 1'b0);
		send_item(16'd1, 1'b1);

		// Narrow the row mid set, past the current column position
		send_item(16'd1, 1'b0);
		send_item(16'd1, 1'b0);
		set_regs(lrh_pkg::MODE_MATRIX, 11'd2);
		send_item(16'd1, 1'b1);

		// Switch from matrix cells to bars mid set
		send_item(16'd1, 1'b0);
		set_regs(lrh_pkg::MODE_HIST, 11'd3);
		send_item(16'd4, 1'b0);
		send_item(16'd7, 1'b1);

		// Random: sender idles lightly, receiver stalls hard, row width zero
		send_idle_pct = 29;
		stall_pct     = 81;
		run_phase(300, 11'd0);

		// Swap the pressure; single-column rows
		send_idle_pct = 81;
		stall_pct     = 29;
		run_phase(300, 11'd1);

		// No idling; rows exactly as wide as the column store
		send_idle_pct = 0;
		stall_pct     = 0;
		run_phase(300, 11'd1024);

		// A histogram longer than the column store, then cells past the
		// column limit in the same set
		set_regs(lrh_pkg::MODE_HIST, 11'd1024);
		for (int k = 0; k < 1025; k++)
			send_item(pick_bar(), 1'b0);
		set_regs(lrh_pkg::MODE_MATRIX, 11'd2047);
		send_long(4, 1'b1);

		wait_idle();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Give up after a generous fixed time
	initial begin
		#50_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

>>> largest_rectangle_histogram.f
hdl/lrh_pkg.sv
hdl/largest_rectangle_histogram.sv
tb/sv/largest_rectangle_histogram_checker.sv
tb/sv/largest_rectangle_histogram_tb.sv
